// ----- design/lss_pkg.sv -----
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants for the light-seeking steering block
// Widths, mode and drive codes, register indexes, reset values and the
// item structs passed between the pipeline stages.
// ----------------------------------------------------------------------------
package lss_pkg;

    localparam int LEVEL_BITS     = 12;
    localparam int SUM_BITS       = LEVEL_BITS + 1;
    localparam int TIME_BITS      = 32;
    localparam int SPEED_BITS     = 8;
    localparam int TIMEOUT_BITS   = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int MODE_CODE_BITS = 2;

    typedef logic [LEVEL_BITS-1:0]     level_t;
    typedef logic [SUM_BITS-1:0]       level_sum_t;
    typedef logic [TIME_BITS-1:0]      ms_t;
    typedef logic [SPEED_BITS-1:0]     speed_t;
    typedef logic [TIMEOUT_BITS-1:0]   timeout_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [MODE_CODE_BITS-1:0] mode_code_t;

    // Controller mode, one-hot internally
    typedef enum logic [2:0] {
        MODE_IDLE     = 3'b001,
        MODE_SEEK     = 3'b010,
        MODE_APPROACH = 3'b100
    } mode_t;

    // Mode codes as reported on the result channel
    localparam mode_code_t MODE_CODE_IDLE     = 2'd0;
    localparam mode_code_t MODE_CODE_SEEK     = 2'd1;
    localparam mode_code_t MODE_CODE_APPROACH = 2'd2;

    typedef enum logic [1:0] {
        CMD_STOP = 2'd0,
        CMD_CCW  = 2'd1,
        CMD_CW   = 2'd2,
        CMD_FWD  = 2'd3
    } drive_t;

    // Configuration register indexes
    localparam cfg_index_t REG_ENABLE         = 3'd0;
    localparam cfg_index_t REG_LIGHT_THRESH   = 3'd1;
    localparam cfg_index_t REG_SEEK_DELTA     = 3'd2;
    localparam cfg_index_t REG_BALANCE_THRESH = 3'd3;
    localparam cfg_index_t REG_SEEK_SPEED     = 3'd4;
    localparam cfg_index_t REG_APPROACH_SPEED = 3'd5;
    localparam cfg_index_t REG_SEEK_TIMEOUT   = 3'd6;

    // Register reset values
    localparam level_t   LIGHT_THRESH_RST   = level_t'(2048);
    localparam level_t   SEEK_DELTA_RST     = level_t'(410);
    localparam level_t   BALANCE_THRESH_RST = level_t'(205);
    localparam speed_t   SEEK_SPEED_RST     = speed_t'(150);
    localparam speed_t   APPROACH_SPEED_RST = speed_t'(180);
    localparam timeout_t SEEK_TIMEOUT_RST   = timeout_t'(5000);

    typedef struct packed {
        level_t left_level;
        level_t right_level;
        ms_t    now_ms;
    } sample_t;

    typedef struct packed {
        mode_code_t mode_now;
        drive_t     drive_cmd;
        speed_t     drive_speed;
        logic       led_seeking;
    } result_t;

    function automatic mode_code_t mode_to_code(input mode_t mode);
        mode_code_t code;
        case (mode)
            MODE_SEEK:     code = MODE_CODE_SEEK;
            MODE_APPROACH: code = MODE_CODE_APPROACH;
            default:       code = MODE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ----- design/lss_in_if.sv -----
// ----------------------------------------------------------------------------
// lss_in_if: sensor update channel
// Valid/ready channel carrying one brightness sample and its timestamp.
// ----------------------------------------------------------------------------
interface lss_in_if
    import lss_pkg::*;
();
    logic   valid;
    logic   ready;
    level_t left_level;
    level_t right_level;
    ms_t    now_ms;

    modport source (output valid, output left_level, output right_level, output now_ms,
                    input ready);
    modport sink   (input valid, input left_level, input right_level, input now_ms,
                    output ready);
endinterface

// ----- design/lss_out_if.sv -----
// ----------------------------------------------------------------------------
// lss_out_if: steering result channel
// Valid/ready channel carrying mode, drive command, speed and LED status.
// ----------------------------------------------------------------------------
interface lss_out_if
    import lss_pkg::*;
();
    logic       valid;
    logic       ready;
    mode_code_t mode_now;
    drive_t     drive_cmd;
    speed_t     drive_speed;
    logic       led_seeking;

    modport source (output valid, output mode_now, output drive_cmd, output drive_speed,
                    output led_seeking, input ready);
    modport sink   (input valid, input mode_now, input drive_cmd, input drive_speed,
                    input led_seeking, output ready);
endinterface

// ----- design/light_seeking_steer_fsm_unit.sv -----
// ----------------------------------------------------------------------------
// light_seeking_steer_fsm_unit: light-seeking steering controller
// An accepted update is held in the input register, then its result is
// loaded into the result register once that register has room.
// Throughput: 1 update per cycle unless the sink stalls; the mode decision
// is one compare stage between the input register and the result register.
// Reset (rst_n, async low): controller disabled, mode idle, motor stopped,
// LED ready, thresholds and speeds at their default values.
// ----------------------------------------------------------------------------
module light_seeking_steer_fsm_unit
    import lss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    lss_in_if.sink     in_ch,
    lss_out_if.source  out_ch,
    input  logic       cfg_we,
    input  cfg_index_t cfg_index,
    input  cfg_data_t  cfg_data
);

    // Pipeline:
    //   in_reg  - holds one sensor item
    //   ctrl    - decides the next mode/motor/LED from the held item and the
    //             current state; state is written when the item moves on, but a
    //             configuration write in that cycle takes priority and skips it
    //   out_reg - holds the result item while the sink stalls
    logic    item_valid;
    sample_t item;
    logic    can_load;
    logic    advance;
    result_t result;

    // item leaves the input register when the result register has room
    assign advance = item_valid && can_load;

    lss_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    lss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    lss_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

endmodule

// ----- design/lss_in_reg.sv -----
// ----------------------------------------------------------------------------
// lss_in_reg: input register stage
// Captures one update item; takes a new one when empty or when the held item moves on.
// ----------------------------------------------------------------------------
module lss_in_reg
    import lss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    lss_in_if.sink    in_ch,
    input  logic      advance,
    output logic      item_valid,
    output sample_t   item
);

    logic    valid_reg;
    logic    valid_next;
    sample_t item_reg;
    logic    take;

    assign in_ch.ready = !valid_reg || advance;
    assign take        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.left_level  <= in_ch.left_level;
            item_reg.right_level <= in_ch.right_level;
            item_reg.now_ms      <= in_ch.now_ms;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- design/lss_ctrl.sv -----
// ----------------------------------------------------------------------------
// lss_ctrl: mode controller
// Configuration registers, mode/motor/LED state and the per-item decision.
// ----------------------------------------------------------------------------
module lss_ctrl
    import lss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  cfg_index_t cfg_index,
    input  cfg_data_t  cfg_data,
    input  logic       advance,
    input  sample_t    item,
    output result_t    result
);

    // configuration
    logic     enable_reg;
    level_t   light_thresh_reg;
    level_t   seek_delta_reg;
    level_t   balance_thresh_reg;
    speed_t   seek_speed_reg;
    speed_t   approach_speed_reg;
    timeout_t seek_timeout_reg;

    // controller state
    mode_t  mode_reg,  mode_next;
    ms_t    start_reg, start_next;
    drive_t drive_reg, drive_next;
    speed_t speed_reg, speed_next;
    logic   led_reg,   led_next;

    // brightness terms
    level_sum_t                sum;
    level_t                    adiff;
    logic                      left_brighter;
    ms_t                       elapsed;
    logic                      light_on;
    logic                      light_dim;
    logic                      turn;
    logic                      centered;
    logic                      reseek;
    logic                      timed_out;
    logic [SUM_BITS+2:0]       sum_x5;
    logic [SUM_BITS+2:0]       thresh_x8;
    logic [LEVEL_BITS+1:0]     adiff_x2;
    logic [LEVEL_BITS+1:0]     delta_x3;

    always_comb
    begin
        sum           = {1'b0, item.left_level} + {1'b0, item.right_level};
        left_brighter = item.left_level > item.right_level;
        adiff         = left_brighter ? (item.left_level - item.right_level)
                                      : (item.right_level - item.left_level);
        elapsed       = item.now_ms - start_reg;

        sum_x5    = {1'b0, sum, 2'b00} + {3'b000, sum};
        thresh_x8 = {1'b0, light_thresh_reg, 3'b000};
        adiff_x2  = {1'b0, adiff, 1'b0};
        delta_x3  = {1'b0, seek_delta_reg, 1'b0} + {2'b00, seek_delta_reg};

        light_on  = sum > {light_thresh_reg, 1'b0};
        light_dim = sum_x5 < thresh_x8;
        turn      = adiff > seek_delta_reg;
        centered  = adiff < balance_thresh_reg;
        reseek    = adiff_x2 > delta_x3;
        timed_out = elapsed > {{(TIME_BITS-TIMEOUT_BITS){1'b0}}, seek_timeout_reg};
    end

    always_comb
    begin
        mode_next  = mode_reg;
        start_next = start_reg;
        drive_next = drive_reg;
        speed_next = speed_reg;
        led_next   = led_reg;

        if (!enable_reg)
        begin
            mode_next  = MODE_IDLE;
            drive_next = CMD_STOP;
            speed_next = '0;
            led_next   = 1'b0;
        end
        else
        begin
            case (mode_reg)
                MODE_IDLE:
                begin
                    if (light_on)
                    begin
                        mode_next  = MODE_SEEK;
                        start_next = item.now_ms;
                    end
                end
                MODE_SEEK:
                begin
                    led_next = 1'b1;
                    if (turn)
                    begin
                        drive_next = left_brighter ? CMD_CCW : CMD_CW;
                        speed_next = seek_speed_reg;
                    end
                    else if (centered)
                    begin
                        drive_next = CMD_STOP;
                        speed_next = '0;
                    end
                    // a centered exit or the timeout moves to approach and restarts the clock
                    if ((!turn && centered) || timed_out)
                    begin
                        mode_next  = MODE_APPROACH;
                        start_next = item.now_ms;
                    end
                end
                MODE_APPROACH:
                begin
                    led_next = 1'b1;
                    if (light_dim)
                    begin
                        drive_next = CMD_STOP;
                        speed_next = '0;
                        mode_next  = MODE_IDLE;
                        start_next = item.now_ms;
                    end
                    else
                    begin
                        drive_next = CMD_FWD;
                        speed_next = approach_speed_reg;
                    end
                    if (reseek)
                    begin
                        mode_next  = MODE_SEEK;
                        start_next = item.now_ms;
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    assign result.mode_now    = mode_to_code(mode_next);
    assign result.drive_cmd   = drive_next;
    assign result.drive_speed = speed_next;
    assign result.led_seeking = led_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg         <= 1'b0;
            light_thresh_reg   <= LIGHT_THRESH_RST;
            seek_delta_reg     <= SEEK_DELTA_RST;
            balance_thresh_reg <= BALANCE_THRESH_RST;
            seek_speed_reg     <= SEEK_SPEED_RST;
            approach_speed_reg <= APPROACH_SPEED_RST;
            seek_timeout_reg   <= SEEK_TIMEOUT_RST;
            mode_reg           <= MODE_IDLE;
            start_reg          <= '0;
            drive_reg          <= CMD_STOP;
            speed_reg          <= '0;
            led_reg            <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:
                begin
                    enable_reg <= cfg_data[0];
                    mode_reg   <= MODE_IDLE;
                    if (!cfg_data[0])
                    begin
                        drive_reg <= CMD_STOP;
                        speed_reg <= '0;
                        led_reg   <= 1'b0;
                    end
                end
                REG_LIGHT_THRESH:   light_thresh_reg   <= cfg_data[LEVEL_BITS-1:0];
                REG_SEEK_DELTA:     seek_delta_reg     <= cfg_data[LEVEL_BITS-1:0];
                REG_BALANCE_THRESH: balance_thresh_reg <= cfg_data[LEVEL_BITS-1:0];
                REG_SEEK_SPEED:     seek_speed_reg     <= cfg_data[SPEED_BITS-1:0];
                REG_APPROACH_SPEED: approach_speed_reg <= cfg_data[SPEED_BITS-1:0];
                REG_SEEK_TIMEOUT:   seek_timeout_reg   <= cfg_data[TIMEOUT_BITS-1:0];
                default:            enable_reg         <= enable_reg;
            endcase
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            drive_reg <= drive_next;
            speed_reg <= speed_next;
            led_reg   <= led_next;
        end
    end

endmodule

// ----- design/lss_out_reg.sv -----
// ----------------------------------------------------------------------------
// lss_out_reg: result register stage
// Holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module lss_out_reg
    import lss_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  result_t  result,
    output logic     can_load,
    lss_out_if.source out_ch
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.mode_now    = result_reg.mode_now;
    assign out_ch.drive_cmd   = result_reg.drive_cmd;
    assign out_ch.drive_speed = result_reg.drive_speed;
    assign out_ch.led_seeking = result_reg.led_seeking;

endmodule

// ----- design/lss_checker.sv -----
// ----------------------------------------------------------------------------
// lss_checker: port-level checks for the steering controller
// Watches the result channel for codes and combinations that cannot occur.
// ----------------------------------------------------------------------------
module lss_checker
    import lss_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input mode_code_t mode_now,
    input drive_t     drive_cmd,
    input speed_t     drive_speed,
    input logic       led_seeking
);

    // stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mode_now) && $stable(drive_cmd)
                                    && $stable(drive_speed) && $stable(led_seeking))
        else $error("result item changed while stalled");

    a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mode_now == MODE_CODE_IDLE || mode_now == MODE_CODE_SEEK
                       || mode_now == MODE_CODE_APPROACH))
        else $error("unused mode code reported");

    a_stop_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_cmd == CMD_STOP |-> drive_speed == '0)
        else $error("nonzero speed with stop command");

    // approaching is only reached through seeking, which lights the LED
    a_approach_led: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_now == MODE_CODE_APPROACH |-> led_seeking)
        else $error("approaching with ready LED");

endmodule

bind light_seeking_steer_fsm_unit lss_checker u_lss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .mode_now    (out_ch.mode_now),
    .drive_cmd   (out_ch.drive_cmd),
    .drive_speed (out_ch.drive_speed),
    .led_seeking (out_ch.led_seeking)
);
